### src/ioul_pkg.sv
package ioul_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  // index width that covers the largest supported list (64 entries) plus one
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_SHOW    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_ROTATE = 3'd4
  } cell_act_e;

  // broadcast to every cell; each cell decides locally from its own index
  typedef struct packed {
    cell_act_e        act;
    logic [IDX_W-1:0] idx;  // 0-based target slot
    logic [IDX_W-1:0] len;  // current list length
  } cell_cmd_t;

endpackage

### src/ioul_in_if.sv
interface ioul_in_if;
  logic                             valid;
  logic                             ready;
  logic [ioul_pkg::OP_W-1:0]        op;
  logic [ioul_pkg::POS_W-1:0]       position;
  logic signed [ioul_pkg::VAL_W-1:0] item_value;
  logic [ioul_pkg::POS_W-1:0]       drop_count;

  modport source (output valid, op, position, item_value, drop_count, input ready);
  modport sink   (input valid, op, position, item_value, drop_count, output ready);
endinterface

### src/ioul_out_if.sv
interface ioul_out_if;
  logic                              valid;
  logic                              ready;
  logic [ioul_pkg::ST_W-1:0]         status;
  logic signed [ioul_pkg::VAL_W-1:0] out_value;
  logic [ioul_pkg::POS_W-1:0]        out_position;
  logic                              last_result;

  modport source (output valid, status, out_value, out_position, last_result, input ready);
  modport sink   (input valid, status, out_value, out_position, last_result, output ready);
endinterface

### src/ioul_cell.sv
module ioul_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  ioul_pkg::cell_cmd_t        cmd_i,
  input  logic [ioul_pkg::VAL_W-1:0] bus_i,
  input  logic [ioul_pkg::VAL_W-1:0] next_i,
  input  logic [ioul_pkg::VAL_W-1:0] prev_i,
  output logic [ioul_pkg::VAL_W-1:0] value_o
);
  import ioul_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx  = IDX_W'(Idx);
  localparam logic [IDX_W-1:0] MyIdx1 = IDX_W'(Idx + 1);

  logic [VAL_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.act)
      ACT_HOLD: val_d = val_q;
      ACT_APPEND: begin
        if (MyIdx == cmd_i.idx) val_d = bus_i;
      end
      ACT_REMOVE: begin
        if (MyIdx >= cmd_i.idx) val_d = next_i;
      end
      ACT_INSERT: begin
        if (MyIdx == cmd_i.idx) val_d = bus_i;
        else if (MyIdx > cmd_i.idx) val_d = prev_i;
      end
      ACT_ROTATE: begin
        // head wraps to the tail slot, the rest move up one
        if (MyIdx1 == cmd_i.len) val_d = bus_i;
        else if (MyIdx1 < cmd_i.len) val_d = next_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

### src/indexed_ordered_list_unit.sv
// Channel  | Dir | Payload                                    | Accept
// ---------+-----+--------------------------------------------+-------------------
// req_i    | in  | op, position, item_value, drop_count       | valid && ready
// rsp_o    | out | status, out_value, out_position, last_result | valid && ready
//
// Append, remove and insert edit the cell row in the accept cycle and give one
// result; the next item can follow in the next cycle once the result is taken.
// Advance by n shortens the list on acceptance, then the row shifts one slot per cycle.
// Show gives one result per element (DEPTH max), the row
// rotating through the head; a stalled result holds it in place.
// rst_ni clears length and control only; cell contents are never reset.
// One output register holds the result; req_i stalls while it is full and not taken.
module indexed_ordered_list_unit #(
  parameter int unsigned DEPTH = ioul_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ioul_in_if.sink     req_i,
  ioul_out_if.source  rsp_o
);
  import ioul_pkg::*;

  localparam int unsigned LEN_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DROP = 3'b010,
    S_SHOW = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] shw_q, shw_d, shw_nx;
  logic [POS_W-1:0] drp_q, drp_d;

  // output register
  logic             ov_q;
  status_e          ost_q;
  logic [VAL_W-1:0] oval_q;
  logic [POS_W-1:0] opos_q;
  logic             olast_q;

  // result to load
  logic             push;
  status_e          pst;
  logic [VAL_W-1:0] pval;
  logic [POS_W-1:0] ppos;
  logic             plast;

  logic             out_free, acc;
  logic [IDX_W-1:0] len_x, pos_x, cnt_x;
  logic             is_empty, is_full, pos_bad;
  op_e              op;

  cell_cmd_t        cmd;
  logic [VAL_W-1:0] bus;
  logic [VAL_W-1:0] cell_val [DEPTH];

  assign out_free    = !ov_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign acc         = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.op);

  assign len_x    = IDX_W'(len_q);
  assign pos_x    = IDX_W'(req_i.position);
  assign cnt_x    = IDX_W'(req_i.drop_count);
  assign is_empty = (len_q == '0);
  assign is_full  = (len_x >= IDX_W'(DEPTH));
  assign pos_bad  = (pos_x == '0) || (pos_x > len_x);
  assign shw_nx   = shw_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    drp_d    = drp_q;
    shw_d    = shw_q;
    cmd.act  = ACT_HOLD;
    cmd.idx  = '0;
    cmd.len  = len_x;
    push     = 1'b0;
    pst      = ST_OK;
    pval     = '0;
    ppos     = '0;
    plast    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          push = 1'b1;
          unique case (op)
            OP_APPEND: begin
              if (is_full) begin
                pst = ST_FULL;
              end else begin
                cmd.act = ACT_APPEND;
                cmd.idx = len_x;
                len_d   = len_q + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                pst = ST_EMPTY;
              end else if (pos_bad) begin
                pst = ST_BAD;
              end else begin
                cmd.act = ACT_REMOVE;
                cmd.idx = pos_x - 1'b1;
                len_d   = len_q - 1'b1;
              end
            end
            OP_INSERT: begin
              // an empty list takes the value at the head, position ignored
              if (is_empty) begin
                cmd.act = ACT_APPEND;
                cmd.idx = len_x;
                len_d   = len_q + 1'b1;
              end else if (is_full) begin
                pst = ST_FULL;
              end else if (pos_bad) begin
                pst = ST_BAD;
              end else begin
                cmd.act = ACT_INSERT;
                cmd.idx = pos_x - 1'b1;
                len_d   = len_q + 1'b1;
              end
            end
            OP_ADVANCE: begin
              if (cnt_x > len_x) begin
                pst = ST_BAD;
              end else if (req_i.drop_count != '0) begin
                // length drops now, the row catches up one slot a cycle
                len_d   = LEN_W'(len_x - cnt_x);
                drp_d   = req_i.drop_count;
                state_d = S_DROP;
              end
            end
            OP_SHOW: begin
              if (is_empty) begin
                pst = ST_EMPTY;
              end else begin
                push    = 1'b0;
                shw_d   = '0;
                state_d = S_SHOW;
              end
            end
            default: pst = ST_BAD;
          endcase
        end
      end
      S_DROP: begin
        cmd.act = ACT_REMOVE;
        cmd.idx = '0;
        drp_d   = drp_q - 1'b1;
        if (drp_q == POS_W'(1)) state_d = S_IDLE;
      end
      S_SHOW: begin
        if (out_free) begin
          push    = 1'b1;
          pval    = cell_val[0];
          ppos    = POS_W'(shw_nx);
          plast   = (shw_nx == len_q);
          cmd.act = ACT_ROTATE;
          shw_d   = shw_nx;
          if (shw_nx == len_q) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // head feeds the tail while rotating, otherwise the incoming value
  assign bus = (cmd.act == ACT_ROTATE) ? cell_val[0] : req_i.item_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] nxt, prv;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_val[i+1];
    end
    if (i == 0) begin : g_head
      assign prv = '0;
    end else begin : g_body
      assign prv = cell_val[i-1];
    end
    ioul_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .bus_i  (bus),
      .next_i (nxt),
      .prev_i (prv),
      .value_o(cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      drp_q   <= '0;
      shw_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      drp_q   <= drp_d;
      shw_q   <= shw_d;
      if (push) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ost_q   <= pst;
      oval_q  <= pval;
      opos_q  <= ppos;
      olast_q <= plast;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.out_value    = oval_q;
  assign rsp_o.out_position = opos_q;
  assign rsp_o.last_result  = olast_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_x <= IDX_W'(DEPTH))
    else $error("list length above depth");

  a_busy_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !acc)
    else $error("item taken while busy");

  a_show_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHOW && push && plast) |=> (state_q == S_IDLE))
    else $error("show did not end after last element");

  a_remove_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op == OP_REMOVE && pst == ST_OK) |=> (len_q == $past(len_q) - 1'b1))
    else $error("remove did not shorten list");
`endif

endmodule
